// ----- rtl/fadd_pkg.sv -----
// Shared constants and types for the single-precision adder.
package fadd_pkg;
    localparam int WordW   = 32;
    localparam int ExpW    = 8;
    localparam int FracW   = 23;
    localparam int SigW    = 27;               // hidden + 23 frac + guard/round/sticky
    localparam int AlignLimit = 27;
    localparam logic [ExpW-1:0] ExpMax = 8'hff;
    localparam logic [WordW-1:0] SignBit = 32'h8000_0000;

    typedef struct packed {
        logic [WordW-1:0] operand_a;
        logic [WordW-1:0] operand_b;
    } pair_t;
endpackage

// ----- rtl/fadd_if.sv -----
// Valid/ready channel carrying a payload of parameterized type.
interface fadd_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/float32_adder_unit.sv -----
// Single-precision IEEE-754 adder, four-stage pipeline with stall.
//
// Channel in_ch carries a pair {operand_a, operand_b}; channel out_ch carries
// sum_bits. A beat moves when valid and ready are both high.
// Each beat passes one register per stage (align, add, normalize, round) on
// its way from in_ch to out_ch.
// Throughput: one beat per cycle while the receiver takes every beat.
// All stages advance together whenever the last stage is empty or its beat
// is being taken; a receiver stall on a full last stage freezes every stage
// and drops the input ready, even while earlier stages are empty.
// Nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload
// registers are not reset. Rounding is nearest-even; a zero exponent field
// counts as zero and returns the other operand unchanged; overflow gives
// infinity and underflow signed zero.
module float32_adder_unit
    import fadd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    fadd_if.sink   in_ch,
    fadd_if.source out_ch
);
    // stage 1: ordered, aligned
    logic        v1_reg;
    logic        byp1_reg;
    logic [31:0] byp_val1_reg;
    logic        sign1_reg, sub1_reg;
    logic [7:0]  ex1_reg;
    logic [26:0] ma1_reg, mb1_reg;
    // stage 2: raw sum
    logic        v2_reg, byp2_reg, sign2_reg;
    logic [31:0] byp_val2_reg;
    logic [7:0]  ex2_reg;
    logic [27:0] s2_reg;
    // stage 3: normalized
    logic        v3_reg, byp3_reg, sign3_reg, zero3_reg;
    logic [31:0] byp_val3_reg;
    logic signed [9:0] ex3_reg;
    logic [26:0] s3_reg;
    // stage 4: output
    logic        v4_reg;
    logic [31:0] res4_reg;

    logic adv;
    assign adv = !v4_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = v4_reg;
    assign out_ch.data  = res4_reg;

    // ---- stage 1 logic
    logic [31:0] a_in, b_in, big, sml;
    logic [7:0]  ea, eb, eb_s, d;
    logic [26:0] mb_full, mb_sh, ma_n;
    logic        lost;
    always_comb
    begin
        a_in = in_ch.data.operand_a;
        b_in = in_ch.data.operand_b;
        ea = a_in[30:23];
        eb = b_in[30:23];
        if (a_in[30:0] < b_in[30:0])
        begin
            big = b_in;
            sml = a_in;
        end
        else
        begin
            big = a_in;
            sml = b_in;
        end
        eb_s = sml[30:23];
        d = big[30:23] - eb_s;
        ma_n = {1'b1, big[22:0], 3'b000};
        mb_full = {1'b1, sml[22:0], 3'b000};
        if (d >= 8'(AlignLimit))
        begin
            mb_sh = 27'd1;
            lost = 1'b0;
        end
        else
        begin
            mb_sh = mb_full >> d[4:0];
            lost = |(mb_full & ((27'd1 << d[4:0]) - 27'd1));
        end
        mb_sh[0] = mb_sh[0] | lost;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp1_reg     <= (ea == 8'd0) || (eb == 8'd0);
            byp_val1_reg <= (ea == 8'd0) ? b_in : a_in;
            sign1_reg    <= big[31];
            sub1_reg     <= a_in[31] ^ b_in[31];
            ex1_reg      <= big[30:23];
            ma1_reg      <= ma_n;
            mb1_reg      <= mb_sh;
        end
    end

    // ---- stage 2: add/subtract
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp2_reg     <= byp1_reg;
            byp_val2_reg <= byp_val1_reg;
            sign2_reg    <= sign1_reg;
            ex2_reg      <= ex1_reg;
            s2_reg       <= sub1_reg ? ({1'b0, ma1_reg} - {1'b0, mb1_reg})
                                     : ({1'b0, ma1_reg} + {1'b0, mb1_reg});
        end
    end

    // ---- stage 3: leading-one search and normalize
    logic [4:0]  lz;
    logic [26:0] s_norm;
    logic signed [9:0] ex_norm;
    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i <= 26; i++)
        begin
            if (s2_reg[i])
                lz = 5'(26 - i);
        end
        if (s2_reg[27])
        begin
            s_norm  = s2_reg[27:1] | {26'd0, s2_reg[0]};
            ex_norm = $signed({2'b00, ex2_reg}) + 10'sd1;
        end
        else
        begin
            s_norm  = s2_reg[26:0] << lz;
            ex_norm = $signed({2'b00, ex2_reg}) - $signed({5'd0, lz});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp3_reg     <= byp2_reg;
            byp_val3_reg <= byp_val2_reg;
            sign3_reg    <= sign2_reg;
            zero3_reg    <= (s2_reg == 28'd0);
            ex3_reg      <= ex_norm;
            s3_reg       <= s_norm;
        end
    end

    // ---- stage 4: round, renormalize, pack
    logic [27:0] s_rnd;
    logic signed [9:0] ex_rnd;
    logic [31:0] res;
    always_comb
    begin
        s_rnd = {1'b0, s3_reg};
        if (s3_reg[2] && (s3_reg[1] || s3_reg[0] || s3_reg[3]))
            s_rnd = s_rnd + 28'd8;
        ex_rnd = ex3_reg;
        if (s_rnd[27])
        begin
            s_rnd  = s_rnd >> 1;
            ex_rnd = ex_rnd + 10'sd1;
        end
        if (byp3_reg)
            res = byp_val3_reg;
        else if (zero3_reg)
            res = 32'd0;
        else if (ex_rnd >= 10'sd255)
            res = {sign3_reg, ExpMax, 23'd0};
        else if (ex_rnd <= 10'sd0)
            res = {sign3_reg, 31'd0};
        else
            res = {sign3_reg, ex_rnd[7:0], s_rnd[25:3]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res4_reg <= res;
    end

    // held result stays put under stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    // an accepted beat occupies stage 1 after its edge
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v1_reg)
        else $error("accepted beat lost");
    // ready only drops while output stalled
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid && !out_ch.ready)
        else $error("spurious input stall");
endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the pipelined single-precision adder.
module tb;
    import fadd_pkg::*;

    logic clk;
    logic rst_n;

    fadd_if #(.payload_t(pair_t))                in_ch  (clk);
    fadd_if #(.payload_t(logic [WordW-1:0]))   out_ch (clk);

    float32_adder_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    localparam int StallLimit = 5000;

    logic [WordW-1:0] expected_sums[$];
    int mismatches  = 0;
    int idle_cycles = 0;
    bit no_idle     = 0;   // both sides run without gaps
    int rx_hold     = 0;   // long receiver stall, counted down by the sink process

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Bit-exact sum in round-to-nearest-even with flush and saturation.
    function automatic logic [WordW-1:0] fp_sum(logic [WordW-1:0] a, logic [WordW-1:0] b);
        logic [ExpW-1:0]  ea, eb;
        logic [WordW-1:0] t, sgn, ma, mb, s, lost;
        int d, p, ex;
        ea = a[30:23];
        eb = b[30:23];
        if (ea == 0)
            return b;
        if (eb == 0)
            return a;
        if (a[30:0] < b[30:0])
        begin
            t = a; a = b; b = t;
            ea = a[30:23];
            eb = b[30:23];
        end
        sgn = a & SignBit;
        ma = {5'b0, 1'b1, a[22:0], 3'b0};
        mb = {5'b0, 1'b1, b[22:0], 3'b0};
        d = int'(ea) - int'(eb);
        if (d >= AlignLimit)
            mb = 1;
        else
        begin
            lost = mb & ((32'd1 << d) - 1);
            mb = mb >> d;
            if (lost != 0)
                mb[0] = 1'b1;
        end
        s = (a[31] == b[31]) ? ma + mb : ma - mb;
        if (s == 0)
            return '0;
        p = 27;
        while (p > 0 && !s[p])
            p--;
        ex = int'(ea);
        if (p == 27)
        begin
            s = (s >> 1) | (s & 1);
            ex++;
        end
        else if (p < 26)
        begin
            s = s << (26 - p);
            ex -= 26 - p;
        end
        if (s[2] && (s[1:0] != 0 || s[3]))
            s += 8;
        if (s[27])
        begin
            s = s >> 1;
            ex++;
        end
        if (ex >= 255)
            return sgn | {1'b0, ExpMax, 23'b0};
        if (ex <= 0)
            return sgn;
        return sgn | (WordW'(ex) << FracW) | {9'b0, s[25:3]};
    endfunction

    task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        mismatches++;
    endtask

    // Offer one operand pair; returns once the beat is taken.
    task automatic send_pair(logic [WordW-1:0] a, logic [WordW-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {a, b};
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_sums.push_back(fp_sum(a, b));
    endtask

    task automatic end_offer();
        in_ch.valid <= 1'b0;
    endtask

    // Sink side: check each beat, then pick the next ready value.
    initial
    begin : sink
        int wait_left;
        logic [WordW-1:0] want;
        wait_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch("unexpected beat", out_ch.data, '0);
                else
                begin
                    want = expected_sums.pop_front();
                    if (out_ch.data !== want)
                        report_mismatch("sum_bits", out_ch.data, want);
                end
                wait_left = no_idle ? 0 : $urandom_range(0, 12);
            end
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (rx_hold > 0)
            begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("float32_adder_unit regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [WordW-1:0] make_float(bit sgn, int ex, logic [FracW-1:0] frac);
        return {sgn, ex[7:0], frac};
    endfunction

    // Operand biased toward interesting regions around a partner exponent.
    function automatic logic [WordW-1:0] pick_operand(logic [WordW-1:0] other);
        int ex;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return make_float(1'($urandom_range(0, 1)), 0, FracW'($urandom));
            2: return make_float(1'($urandom_range(0, 1)), $urandom_range(1, 8),
                                 FracW'($urandom));
            3: return make_float(1'($urandom_range(0, 1)), $urandom_range(246, 255),
                                 FracW'($urandom));
            4: return {~other[31], other[30:23], other[22:0] ^ 23'($urandom_range(0, 15))};
            default:
            begin
                ex = int'(other[30:23]) - $urandom_range(0, 30);
                if (ex < 1)
                    ex = 1;
                return make_float(1'($urandom_range(0, 1)), ex, FracW'($urandom));
            end
        endcase
    endfunction

    task automatic test_directed();
        send_pair(32'h3f80_0000, 32'h3f80_0000);   // 1 + 1
        send_pair(32'h3f80_0000, 32'hbf80_0000);   // exact cancellation
        send_pair(32'hbf80_0000, 32'h3f80_0000);
        send_pair(32'h0000_0005, 32'h3f80_0000);   // zero exponent on a
        send_pair(32'hc040_0000, 32'h807f_ffff);   // zero exponent on b
        send_pair(32'h8000_0001, 32'h007f_ffff);   // both zero exponent
        send_pair(32'h7f7f_ffff, 32'h7f7f_ffff);   // overflow
        send_pair(32'hff7f_ffff, 32'hff00_0000);
        send_pair(32'h7f80_0000, 32'h3f80_0000);   // exponent 255 taken as ordinary
        send_pair(32'hffff_ffff, 32'h7fff_ffff);
        send_pair(32'h0080_0001, 32'h8080_0000);   // underflow to zero
        send_pair(32'h8080_0000, 32'h0080_0002);
        send_pair(32'h3f80_0000, 32'h3380_0000);   // tie, stays even
        send_pair(32'h3f80_0001, 32'h3380_0000);   // tie, rounds up
        send_pair(32'h3fff_ffff, 32'h3400_0000);   // carry out of the significand add
        send_pair(32'h3f80_0000, 32'h3000_0000);   // shift past the datapath
        send_pair(32'h3f80_0000, 32'hb2ff_ffff);   // sticky only, subtract
        send_pair(32'h3f80_0000, 32'hbf7f_ffff);   // deep normalization
        send_pair(32'h4b7f_ffff, 32'hcb7f_fffe);
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hffff_ffff, 32'hffff_ffff);
        end_offer();
    endtask

    task automatic test_random(int count);
        logic [WordW-1:0] a;
        repeat (count)
        begin
            a = $urandom;
            if ($urandom_range(0, 3) == 0)
                a = make_float(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                               FracW'($urandom));
            if ($urandom_range(0, 1))
                send_pair(a, pick_operand(a));
            else
                send_pair(pick_operand(a), a);
        end
        end_offer();
    endtask

    // Back-to-back beats into a stalled receiver fill the pipeline.
    task automatic test_backpressure();
        no_idle = 1;
        rx_hold = 300;
        test_random(40);
        no_idle = 0;
    endtask

    task automatic test_streaming();
        no_idle = 1;
        test_random(200);
        no_idle = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_streaming();
        test_random(790);
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("float32_adder_unit regression: pass");
        else
            $display("float32_adder_unit regression: fail");
        $finish;
    end
endmodule
